>>> design/fsmtte_pkg.sv
// shared types, codes and fixed constants for the free space monitor
// no dependencies; used by every other file of the block
`default_nettype none

package fsmtte_pkg;

    // fixed field widths
    localparam int BLOCK_COUNT_BITS = 48;
    localparam int ELAPSED_W        = 16;
    localparam int ACC_W            = 17;
    localparam int PERIOD_W         = 16;
    localparam int PERCENT_INT_BITS = 7;
    localparam int LIMIT_W          = 16;
    localparam int HOURS_W          = 24;
    localparam int HOUR_FRAC_BITS   = 8;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    // arithmetic constants
    localparam logic [6:0]         PERCENT_SCALE    = 7'd100;
    localparam logic [11:0]        SECONDS_PER_HOUR = 12'd3600;
    localparam logic [HOURS_W:0]   ONE_HOUR_Q8      = 25'd256;
    localparam logic [HOURS_W:0]   ONE_DAY_Q8       = 25'd6144;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAME_DEVICE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PERIOD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_PERCENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PERCENT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOURS_LIMIT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DAYS_LIMIT_HOURS = 3'd5;

    // configuration reset values
    localparam logic [PERIOD_W-1:0]         RST_CHECK_PERIOD     = 16'd600;
    localparam logic [PERCENT_INT_BITS-1:0] RST_CRITICAL_PERCENT = 7'd5;
    localparam logic [PERCENT_INT_BITS-1:0] RST_LOW_PERCENT      = 7'd10;
    localparam logic [LIMIT_W-1:0]          RST_HOURS_LIMIT      = 16'd72;
    localparam logic [LIMIT_W-1:0]          RST_DAYS_LIMIT_HOURS = 16'd336;

    // level codes
    localparam logic [1:0] LEVEL_NORMAL   = 2'd0;
    localparam logic [1:0] LEVEL_LOW      = 2'd1;
    localparam logic [1:0] LEVEL_CRITICAL = 2'd2;
    localparam logic [1:0] LEVEL_NOT_READ = 2'd3;

    // report codes
    localparam logic [1:0] REPORT_NONE  = 2'd0;
    localparam logic [1:0] REPORT_HOURS = 2'd1;
    localparam logic [1:0] REPORT_DAYS  = 2'd2;

    typedef struct packed {
        logic [ELAPSED_W-1:0]        elapsed_seconds;
        logic                        volume_a_ok;
        logic [BLOCK_COUNT_BITS-1:0] free_blocks_a;
        logic [BLOCK_COUNT_BITS-1:0] total_blocks_a;
        logic                        volume_b_ok;
        logic [BLOCK_COUNT_BITS-1:0] free_blocks_b;
        logic [BLOCK_COUNT_BITS-1:0] total_blocks_b;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         level_a;
        logic [1:0]         report_a;
        logic [HOURS_W-1:0] hours_left_a;
        logic [1:0]         level_b;
        logic [1:0]         report_b;
        logic [HOURS_W-1:0] hours_left_b;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VOL,
        ST_PCT_WAIT,
        ST_PCT_EVAL,
        ST_MUL,
        ST_PRED_START,
        ST_PRED_WAIT,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_PREP,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

endpackage

`default_nettype wire

>>> design/fsmtte_div.sv
// radix-2 digit-serial saturating divider, one quotient bit per cycle
// depends on fsmtte_pkg for the state type
`default_nettype none

module fsmtte_div #(
    parameter int W     = 59,
    parameter int Q_W   = 24,
    parameter int CNT_W = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [W-1:0]     i_num,
    input  wire logic [W-1:0]     i_den,
    input  wire logic [CNT_W-1:0] i_steps,
    output logic                  o_done,
    output logic [Q_W-1:0]        o_quot
);

    fsmtte_pkg::t_div_state r_state;
    fsmtte_pkg::t_div_state n_state;

    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_sat;
    logic [Q_W-1:0]   r_quot;

    logic             w_load;
    logic             w_prep;
    logic             w_step;
    logic [W:0]       w_rem2;
    logic [W:0]       w_diff;
    logic             w_ge;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsmtte_pkg::DIV_IDLE: begin
                if (i_start) begin
                    n_state = fsmtte_pkg::DIV_PREP;
                end
            end
            fsmtte_pkg::DIV_PREP: n_state = fsmtte_pkg::DIV_RUN;
            fsmtte_pkg::DIV_RUN: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = fsmtte_pkg::DIV_DONE;
                end
            end
            fsmtte_pkg::DIV_DONE: n_state = fsmtte_pkg::DIV_IDLE;
            default: n_state = fsmtte_pkg::DIV_IDLE;
        endcase
    end

    // outputs and strobes
    always_comb begin
        w_load = 1'b0;
        w_prep = 1'b0;
        w_step = 1'b0;
        o_done = 1'b0;
        unique case (r_state)
            fsmtte_pkg::DIV_IDLE: w_load = i_start;
            fsmtte_pkg::DIV_PREP: w_prep = 1'b1;
            fsmtte_pkg::DIV_RUN:  w_step = 1'b1;
            fsmtte_pkg::DIV_DONE: o_done = 1'b1;
            default: ;
        endcase
    end

    // one trial subtract against the pre-shifted divisor
    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});
    assign w_diff = w_rem2 - {1'b0, r_den};
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsmtte_pkg::DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_cnt  <= i_steps;
            r_quot <= '0;
        end
        // quotient would not fit: every digit becomes one
        if (w_prep) begin
            r_sat <= (r_rem >= r_den);
        end
        if (w_step) begin
            r_rem  <= w_ge ? w_diff[W-1:0] : w_rem2[W-1:0];
            r_quot <= {r_quot[Q_W-2:0], r_sat | w_ge};
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> design/free_space_monitor_time_to_empty.sv
// free space monitor top level: two volumes, level, time-to-empty, rate-limited report
// a tick that does not close a check period only updates the accumulator; a closing tick gives its
// transaction after the shared divider, producing one quotient bit per cycle, has run up to four
// divisions per check
// one tick in flight at a time; the result register frees the input side while it waits
// reset (synchronous, active low) clears accumulator, history and loads config defaults
`default_nettype none

module free_space_monitor_time_to_empty #(
    parameter int PERCENT_FRACTION_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // input channel
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire fsmtte_pkg::t_in_item                   i_in_data,
    // result channel
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output fsmtte_pkg::t_out_item                       o_out_data,
    // configuration writes
    input  wire logic                                   i_cfg_we,
    input  wire logic [fsmtte_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [fsmtte_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // percent is Q7.F
    localparam int PW        = fsmtte_pkg::PERCENT_INT_BITS + PERCENT_FRACTION_BITS;
    localparam int BC        = fsmtte_pkg::BLOCK_COUNT_BITS;
    localparam int HW        = fsmtte_pkg::HOURS_W;
    localparam int FB        = fsmtte_pkg::HOUR_FRAC_BITS;
    // free * 100
    localparam int PCT_NUM_W = BC + fsmtte_pkg::PERCENT_INT_BITS;
    // percent * period, then scaled to Q8 hours
    localparam int MUL_H_W   = PW + fsmtte_pkg::PERIOD_W;
    // drop * 3600
    localparam int DEN_H_W   = PW + 12;
    // divider operand width covers both percent and hours divisions
    localparam int DIV_W     = (PCT_NUM_W > DEN_H_W + HW) ? PCT_NUM_W : DEN_H_W + HW;
    localparam int Q_W       = (PW > HW) ? PW : HW;
    localparam int CNT_W     = $clog2(Q_W + 1);

    localparam logic VOL_A = 1'b0;
    localparam logic VOL_B = 1'b1;

    // configuration
    logic                                          r_same_device;
    logic [fsmtte_pkg::PERIOD_W-1:0]               r_check_period;
    logic [fsmtte_pkg::PERCENT_INT_BITS-1:0]       r_critical_percent;
    logic [fsmtte_pkg::PERCENT_INT_BITS-1:0]       r_low_percent;
    logic [fsmtte_pkg::LIMIT_W-1:0]                r_hours_limit;
    logic [fsmtte_pkg::LIMIT_W-1:0]                r_days_limit_hours;

    // history kept across checks
    logic [fsmtte_pkg::ACC_W-1:0]                  r_acc;
    logic [PW-1:0]                                 r_prev_a;
    logic [PW-1:0]                                 r_prev_b;
    logic [HW-1:0]                                 r_rep_a;
    logic [HW-1:0]                                 r_rep_b;

    // sequencer
    fsmtte_pkg::t_state                            r_state;
    fsmtte_pkg::t_state                            n_state;
    logic                                          r_vol;

    // working registers
    fsmtte_pkg::t_in_item                          r_in;
    logic [PW-1:0]                                 r_pct;
    logic [PW-1:0]                                 r_drop;
    logic [1:0]                                    r_level;
    logic [MUL_H_W-1:0]                            r_num_h;
    logic [DEN_H_W-1:0]                            r_den_h;
    logic [HW-1:0]                                 r_pred;
    fsmtte_pkg::t_out_item                         r_res;
    fsmtte_pkg::t_out_item                         r_out;
    logic                                          r_out_valid;

    // combinational
    logic                                          w_in_acc;
    logic [fsmtte_pkg::ACC_W-1:0]                  w_acc_sum;
    logic                                          w_check;
    logic                                          w_out_free;
    logic                                          w_last;
    logic                                          w_sel_ok;
    logic [BC-1:0]                                 w_sel_free;
    logic [BC-1:0]                                 w_sel_total;
    logic [PW-1:0]                                 w_sel_prev;
    logic [HW-1:0]                                 w_sel_rep;
    logic                                          w_vol_ok;
    logic [1:0]                                    w_level;
    logic                                          w_no_pred;
    logic [HW:0]                                   w_pred_hour;
    logic [HW:0]                                   w_pred_day;
    logic                                          w_hours_hit;
    logic                                          w_days_hit;
    logic [1:0]                                    w_report;

    logic                                          w_div_start;
    logic [DIV_W-1:0]                              w_div_num;
    logic [DIV_W-1:0]                              w_div_den;
    logic [CNT_W-1:0]                              w_div_steps;
    logic                                          w_div_done;
    logic [Q_W-1:0]                                w_div_quot;

    logic                                          w_vol_done;
    logic [1:0]                                    w_res_level;
    logic [1:0]                                    w_res_report;
    logic [HW-1:0]                                 w_res_hours;
    logic                                          w_prev_we;
    logic                                          w_rep_we;
    logic [HW-1:0]                                 w_rep_val;
    logic                                          w_pct_ld;
    logic                                          w_drop_ld;
    logic                                          w_mul_ld;
    logic                                          w_pred_ld;
    logic                                          w_emit;

    // handshakes
    assign o_in_stall  = (r_state != fsmtte_pkg::ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // seconds accumulator is 17 bits, wide enough not to wrap; a check closes once it reaches the period
    assign w_acc_sum = r_acc + fsmtte_pkg::ACC_W'(i_in_data.elapsed_seconds);
    assign w_check   = (w_acc_sum >= {1'b0, r_check_period});

    // per-volume selection
    assign w_last      = (r_vol == VOL_B);
    assign w_sel_ok    = w_last ? r_in.volume_b_ok    : r_in.volume_a_ok;
    assign w_sel_free  = w_last ? r_in.free_blocks_b  : r_in.free_blocks_a;
    assign w_sel_total = w_last ? r_in.total_blocks_b : r_in.total_blocks_a;
    assign w_sel_prev  = w_last ? r_prev_b : r_prev_a;
    assign w_sel_rep   = w_last ? r_rep_b  : r_rep_a;

    // shared device: volume b is never read
    assign w_vol_ok = w_sel_ok && (w_sel_total != '0) && !(w_last && r_same_device);

    // level thresholds are whole percents
    always_comb begin
        if (r_pct < {r_critical_percent, {PERCENT_FRACTION_BITS{1'b0}}}) begin
            w_level = fsmtte_pkg::LEVEL_CRITICAL;
        end else if (r_pct < {r_low_percent, {PERCENT_FRACTION_BITS{1'b0}}}) begin
            w_level = fsmtte_pkg::LEVEL_LOW;
        end else begin
            w_level = fsmtte_pkg::LEVEL_NORMAL;
        end
    end

    // first sample or no drop: no prediction this check
    assign w_no_pred = (w_sel_prev == '0) || (w_sel_prev <= r_pct);

    // report decision, rate limited against the last reported prediction
    assign w_pred_hour = {1'b0, r_pred} + fsmtte_pkg::ONE_HOUR_Q8;
    assign w_pred_day  = {1'b0, r_pred} + fsmtte_pkg::ONE_DAY_Q8;
    assign w_hours_hit = (r_pred <= {r_hours_limit, {FB{1'b0}}}) &&
                         ((w_sel_rep == '0) || ({1'b0, w_sel_rep} > w_pred_hour));
    assign w_days_hit  = (r_pred <= {r_days_limit_hours, {FB{1'b0}}}) &&
                         ((w_sel_rep == '0) || ({1'b0, w_sel_rep} > w_pred_day));

    always_comb begin
        if (w_hours_hit) begin
            w_report = fsmtte_pkg::REPORT_HOURS;
        end else if (w_days_hit) begin
            w_report = fsmtte_pkg::REPORT_DAYS;
        end else begin
            w_report = fsmtte_pkg::REPORT_NONE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsmtte_pkg::ST_IDLE: begin
                if (w_in_acc && w_check) begin
                    n_state = fsmtte_pkg::ST_VOL;
                end
            end
            fsmtte_pkg::ST_VOL: begin
                if (w_vol_ok) begin
                    n_state = fsmtte_pkg::ST_PCT_WAIT;
                end else begin
                    n_state = w_last ? fsmtte_pkg::ST_EMIT : fsmtte_pkg::ST_VOL;
                end
            end
            fsmtte_pkg::ST_PCT_WAIT: begin
                if (w_div_done) begin
                    n_state = fsmtte_pkg::ST_PCT_EVAL;
                end
            end
            fsmtte_pkg::ST_PCT_EVAL: begin
                if (w_no_pred) begin
                    n_state = w_last ? fsmtte_pkg::ST_EMIT : fsmtte_pkg::ST_VOL;
                end else begin
                    n_state = fsmtte_pkg::ST_MUL;
                end
            end
            fsmtte_pkg::ST_MUL:        n_state = fsmtte_pkg::ST_PRED_START;
            fsmtte_pkg::ST_PRED_START: n_state = fsmtte_pkg::ST_PRED_WAIT;
            fsmtte_pkg::ST_PRED_WAIT: begin
                if (w_div_done) begin
                    n_state = fsmtte_pkg::ST_DECIDE;
                end
            end
            fsmtte_pkg::ST_DECIDE: begin
                n_state = w_last ? fsmtte_pkg::ST_EMIT : fsmtte_pkg::ST_VOL;
            end
            fsmtte_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = fsmtte_pkg::ST_IDLE;
                end
            end
            default: n_state = fsmtte_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_div_start  = 1'b0;
        w_div_num    = '0;
        w_div_den    = '0;
        w_div_steps  = '0;
        w_vol_done   = 1'b0;
        w_res_level  = fsmtte_pkg::LEVEL_NOT_READ;
        w_res_report = fsmtte_pkg::REPORT_NONE;
        w_res_hours  = '0;
        w_prev_we    = 1'b0;
        w_rep_we     = 1'b0;
        w_rep_val    = '0;
        w_pct_ld     = 1'b0;
        w_drop_ld    = 1'b0;
        w_mul_ld     = 1'b0;
        w_pred_ld    = 1'b0;
        w_emit       = 1'b0;
        unique case (r_state)
            fsmtte_pkg::ST_VOL: begin
                if (w_vol_ok) begin
                    // percent = free*100*2^F / total, divisor pre-shifted by the 7 integer bits
                    w_div_start = 1'b1;
                    w_div_num   = DIV_W'(PCT_NUM_W'(w_sel_free) *
                                         PCT_NUM_W'(fsmtte_pkg::PERCENT_SCALE));
                    w_div_den   = DIV_W'({w_sel_total,
                                          {fsmtte_pkg::PERCENT_INT_BITS{1'b0}}});
                    w_div_steps = CNT_W'(PW);
                end else begin
                    // not read: level 3, nothing else, history kept
                    w_vol_done = 1'b1;
                end
            end
            fsmtte_pkg::ST_PCT_WAIT: w_pct_ld = w_div_done;
            fsmtte_pkg::ST_PCT_EVAL: begin
                if (w_no_pred) begin
                    w_vol_done  = 1'b1;
                    w_res_level = w_level;
                    w_prev_we   = 1'b1;
                    // a rise or an unchanged percent clears the last reported prediction
                    w_rep_we    = (w_sel_prev != '0);
                end else begin
                    w_drop_ld = 1'b1;
                end
            end
            fsmtte_pkg::ST_MUL: w_mul_ld = 1'b1;
            fsmtte_pkg::ST_PRED_START: begin
                // hours = pct*period*256 / (3600*drop), divisor pre-shifted by 24 bits
                w_div_start = 1'b1;
                w_div_num   = DIV_W'({r_num_h, {FB{1'b0}}});
                w_div_den   = DIV_W'({r_den_h, {HW{1'b0}}});
                w_div_steps = CNT_W'(HW);
            end
            fsmtte_pkg::ST_PRED_WAIT: w_pred_ld = w_div_done;
            fsmtte_pkg::ST_DECIDE: begin
                w_vol_done   = 1'b1;
                w_res_level  = r_level;
                w_res_report = w_report;
                w_res_hours  = r_pred;
                w_prev_we    = 1'b1;
                w_rep_we     = (w_report != fsmtte_pkg::REPORT_NONE);
                w_rep_val    = r_pred;
            end
            fsmtte_pkg::ST_EMIT: w_emit = w_out_free;
            default: ;
        endcase
    end

    fsmtte_div #(
        .W     (DIV_W),
        .Q_W   (Q_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_steps (w_div_steps),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // control state, history and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= fsmtte_pkg::ST_IDLE;
            r_vol              <= VOL_A;
            r_acc              <= '0;
            r_prev_a           <= '0;
            r_prev_b           <= '0;
            r_rep_a            <= '0;
            r_rep_b            <= '0;
            r_out_valid        <= 1'b0;
            r_same_device      <= 1'b0;
            r_check_period     <= fsmtte_pkg::RST_CHECK_PERIOD;
            r_critical_percent <= fsmtte_pkg::RST_CRITICAL_PERCENT;
            r_low_percent      <= fsmtte_pkg::RST_LOW_PERCENT;
            r_hours_limit      <= fsmtte_pkg::RST_HOURS_LIMIT;
            r_days_limit_hours <= fsmtte_pkg::RST_DAYS_LIMIT_HOURS;
        end else begin
            r_state <= n_state;

            if (w_in_acc) begin
                r_acc <= w_check ? '0 : w_acc_sum;
                r_vol <= VOL_A;
            end else if (w_vol_done && !w_last) begin
                r_vol <= VOL_B;
            end

            if (w_prev_we) begin
                if (w_last) begin
                    r_prev_b <= r_pct;
                end else begin
                    r_prev_a <= r_pct;
                end
            end
            if (w_rep_we) begin
                if (w_last) begin
                    r_rep_b <= w_rep_val;
                end else begin
                    r_rep_a <= w_rep_val;
                end
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // indexes past the list are dropped
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fsmtte_pkg::CFG_SAME_DEVICE:
                        r_same_device <= i_cfg_data[0];
                    fsmtte_pkg::CFG_CHECK_PERIOD:
                        r_check_period <= i_cfg_data;
                    fsmtte_pkg::CFG_CRITICAL_PERCENT:
                        r_critical_percent <= i_cfg_data[fsmtte_pkg::PERCENT_INT_BITS-1:0];
                    fsmtte_pkg::CFG_LOW_PERCENT:
                        r_low_percent <= i_cfg_data[fsmtte_pkg::PERCENT_INT_BITS-1:0];
                    fsmtte_pkg::CFG_HOURS_LIMIT:
                        r_hours_limit <= i_cfg_data;
                    fsmtte_pkg::CFG_DAYS_LIMIT_HOURS:
                        r_days_limit_hours <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_data;
        end
        if (w_pct_ld) begin
            r_pct <= w_div_quot[PW-1:0];
        end
        if (w_drop_ld) begin
            r_drop  <= w_sel_prev - r_pct;
            r_level <= w_level;
        end
        if (w_mul_ld) begin
            r_num_h <= MUL_H_W'(r_pct) * MUL_H_W'(r_check_period);
            r_den_h <= DEN_H_W'(r_drop) * DEN_H_W'(fsmtte_pkg::SECONDS_PER_HOUR);
        end
        if (w_pred_ld) begin
            r_pred <= w_div_quot[HW-1:0];
        end
        if (w_vol_done) begin
            if (w_last) begin
                r_res.level_b      <= w_res_level;
                r_res.report_b     <= w_res_report;
                r_res.hours_left_b <= w_res_hours;
            end else begin
                r_res.level_a      <= w_res_level;
                r_res.report_a     <= w_res_report;
                r_res.hours_left_a <= w_res_hours;
            end
        end
        if (w_emit) begin
            r_out <= r_res;
        end
    end

endmodule

`default_nettype wire

>>> design/fsmtte_chk.sv
// port-level checker for the free space monitor, bound to the top level
// depends on fsmtte_pkg for level and report codes
`default_nettype none

module fsmtte_chk (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_in_stall,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire fsmtte_pkg::t_out_item o_out_data
);

    // a stalled result transaction stays offered
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // and keeps its payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // a volume that was not read carries no prediction and no report
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.level_a != fsmtte_pkg::LEVEL_NOT_READ ||
             (o_out_data.report_a == fsmtte_pkg::REPORT_NONE &&
              o_out_data.hours_left_a == '0)) &&
            (o_out_data.level_b != fsmtte_pkg::LEVEL_NOT_READ ||
             (o_out_data.report_b == fsmtte_pkg::REPORT_NONE &&
              o_out_data.hours_left_b == '0)))
        else $error("not read volume carries a prediction or report");

    // a new result only comes out of a check in progress
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a check in progress");

endmodule

bind free_space_monitor_time_to_empty fsmtte_chk u_fsmtte_chk (.*);

`default_nettype wire
